// ----- rtl/tta_pkg.sv -----
// Shared constants and types for the touch-to-thumbstick block.
package tta_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_AREA_MID_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_MID_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ASPECT_RATIO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONLY_MAX_AXIS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 3'd6;

    localparam logic [1:0] MODE_AREA = 2'd0;
    localparam logic [1:0] MODE_POINT = 2'd1;
    localparam logic [1:0] MODE_SWIPE = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic [1:0] KEY_UP = 2'd0;
    localparam logic [1:0] KEY_PRESSED = 2'd1;
    localparam logic [1:0] KEY_HELD = 2'd2;
    localparam logic [1:0] KEY_RELEASED = 2'd3;

    localparam logic [15:0] THRESH_Q15 = 16'd3277;
    localparam logic [15:0] ONE_Q15 = 16'd32768;

    // Width of the shared divider operands: the vertical direction dividend stays below 2^39.
    localparam int DIV_W = 40;
    localparam int DIV_CNT_W = 6;

    // Square root input (sum of squares below 2^49) and root width.
    localparam int SQ_W = 50;
    localparam int LEN_W = 25;

    typedef struct packed {
        logic                start;
        logic [DIV_W-1:0]    num;
        logic [DIV_W-1:0]    den;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DIV_W-1:0]    quo;
    } t_div_rsp;

endpackage

// ----- rtl/tta_divider.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
module tta_divider
    import tta_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_W:0]       w_trial;
    logic [DIV_W:0]       w_diff;

    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_diff = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt <= DIV_CNT_W'(DIV_W);
                r_quo <= i_req.num;
                r_rem <= '0;
                r_den <= i_req.den;
            end else if (r_busy) begin
                if (!w_diff[DIV_W]) begin
                    r_rem <= w_diff[DIV_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial[DIV_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo = r_quo;

endmodule

// ----- rtl/tta_isqrt.sv -----
// Bit-pair integer square root, one result bit per cycle.
module tta_isqrt
    import tta_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SQ_W-1:0]  i_val,
    output logic             o_done,
    output logic [LEN_W-1:0] o_root
);

    logic [SQ_W-1:0] r_v;
    logic [SQ_W-1:0] r_r;
    logic [SQ_W-1:0] r_bit;
    logic            r_busy;
    logic            r_done;
    logic [SQ_W-1:0] w_sum;

    assign w_sum = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_v <= i_val;
                r_r <= '0;
                r_bit <= SQ_W'(1) << (SQ_W - 2);
            end else if (r_busy) begin
                if (r_v >= w_sum) begin
                    r_v <= r_v - w_sum;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[LEN_W-1:0];

endmodule

// ----- rtl/touch_to_thumbstick_axes.sv -----
// Top level: touch position to four stick axis values, sequenced over shared units.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------------
//  in      | input     | i_valid / o_stall  | key_state, touch_x, touch_y, frame_time
//  out     | output    | o_valid / i_stall  | left/right/up/down value, is_active
//  cfg     | input     | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// An active beat passes through easing (swipe mode only), centering, the first of four
// passes of the shared divider, squaring, the square root, the other three divider
// passes and the output products. A zero radius or a zero offset stops after the root;
// an inactive beat goes straight to the done state. Reset is synchronous and active low;
// it clears the sequencer, the stick state and the registers to their reset values. A
// result waits in the output register while the sink stalls; the next beat is taken once
// that result has left.
module touch_to_thumbstick_axes
    import tta_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_key_state,
    input  logic [15:0]           i_touch_x,
    input  logic [15:0]           i_touch_y,
    input  logic [15:0]           i_frame_time,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [15:0]           o_left_value,
    output logic [15:0]           o_right_value,
    output logic [15:0]           o_up_value,
    output logic [15:0]           o_down_value,
    output logic                  o_is_active,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_EASE_X = 5'd1;
    localparam logic [4:0] S_EASE_Y = 5'd2;
    localparam logic [4:0] S_CENTER = 5'd3;
    localparam logic [4:0] S_ASP = 5'd4;
    localparam logic [4:0] S_ASP_W = 5'd5;
    localparam logic [4:0] S_SQ_X = 5'd6;
    localparam logic [4:0] S_SQ_Y = 5'd7;
    localparam logic [4:0] S_ROOT = 5'd8;
    localparam logic [4:0] S_ROOT_W = 5'd9;
    localparam logic [4:0] S_STR = 5'd10;
    localparam logic [4:0] S_STR_W = 5'd11;
    localparam logic [4:0] S_NX = 5'd12;
    localparam logic [4:0] S_NX_W = 5'd13;
    localparam logic [4:0] S_NY = 5'd14;
    localparam logic [4:0] S_NY_W = 5'd15;
    localparam logic [4:0] S_MUL_X = 5'd16;
    localparam logic [4:0] S_MUL_Y = 5'd17;
    localparam logic [4:0] S_OUT = 5'd18;
    localparam logic [4:0] S_DONE = 5'd19;

    // Configuration registers.
    logic [15:0] r_mid_x, r_mid_y, r_radius, r_aspect;
    logic [1:0]  r_mode;
    logic        r_max_axis, r_enabled;

    // Stick state.
    logic [15:0] r_cx, r_cy, r_lx, r_ly;

    // Working registers.
    logic [4:0]       r_state;
    logic [1:0]       r_ks;
    logic [15:0]      r_tx, r_ty, r_ft;
    logic             r_xneg, r_yneg;
    logic [15:0]      r_ax;
    logic [23:0]      r_ay;
    logic [SQ_W-1:0]  r_sq;
    logic [LEN_W-1:0] r_len;
    logic [15:0]      r_str, r_nx, r_ny;
    logic [16:0]      r_vx, r_vy;
    logic             r_valid;
    logic [15:0]      r_l, r_r, r_u, r_d;
    logic             r_act;

    t_div_req         w_div_req;
    t_div_rsp         w_div_rsp;
    logic             w_sq_start, w_sq_done;
    logic [LEN_W-1:0] w_root;
    logic             w_accept;

    // Shared multiplier operands, one product a cycle.
    logic [23:0] w_ma, w_mb;
    logic [47:0] w_mp;
    assign w_mp = w_ma * w_mb;

    assign o_stall = (r_state != S_IDLE) || r_valid;
    assign w_accept = i_valid && !o_stall;

    tta_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    tta_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (r_sq),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // Easing fraction t = min(1, 4*dt), Q1.16 with 17 bits.
    logic [17:0] w_t4;
    logic [16:0] w_t;
    assign w_t4 = {r_ft, 2'b00};
    assign w_t = (w_t4 > 18'd65536) ? 17'd65536 : w_t4[16:0];

    // Distances from the centre to the previous touch, used by swipe easing.
    logic [15:0] w_lx_diff, w_ly_diff;
    assign w_lx_diff = (r_lx >= r_cx) ? r_lx - r_cx : r_cx - r_lx;
    assign w_ly_diff = (r_ly >= r_cy) ? r_ly - r_cy : r_cy - r_ly;

    // Eased centre: the product is truncated, so the centre never passes the target.
    logic [15:0] w_ease_x, w_ease_y;
    assign w_ease_x = (r_lx >= r_cx) ? r_cx + w_mp[31:16] : r_cx - w_mp[31:16];
    assign w_ease_y = (r_ly >= r_cy) ? r_cy + w_mp[31:16] : r_cy - w_mp[31:16];

    // Offset magnitudes of the current touch from the centre.
    logic [15:0] w_ax_abs, w_ay_abs;
    assign w_ax_abs = (r_tx < r_cx) ? r_cx - r_tx : r_tx - r_cx;
    assign w_ay_abs = (r_ty < r_cy) ? r_cy - r_ty : r_ty - r_cy;

    // A zero aspect ratio is taken as the smallest step, 1/256.
    logic [15:0] w_asp;
    assign w_asp = (r_aspect == 16'd0) ? 16'd1 : r_aspect;

    // The strength numerator is the length clipped at the radius.
    logic [15:0] w_minlr;
    assign w_minlr = (r_len < {9'd0, r_radius}) ? r_len[15:0] : r_radius;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_EASE_X: begin
                w_ma = {8'd0, w_lx_diff};
                w_mb = {7'd0, w_t};
            end
            S_EASE_Y: begin
                w_ma = {8'd0, w_ly_diff};
                w_mb = {7'd0, w_t};
            end
            S_SQ_X: begin
                w_ma = {8'd0, r_ax};
                w_mb = {8'd0, r_ax};
            end
            S_SQ_Y: begin
                w_ma = r_ay;
                w_mb = r_ay;
            end
            S_MUL_X: begin
                w_ma = {8'd0, r_nx};
                w_mb = {8'd0, r_str};
            end
            S_MUL_Y: begin
                w_ma = {8'd0, r_ny};
                w_mb = {8'd0, r_str};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // Each division is started by a one-cycle request from its issue state.
    always_comb begin
        w_div_req.start = 1'b0;
        w_div_req.num = '0;
        w_div_req.den = '0;
        unique case (r_state)
            S_ASP: begin
                w_div_req.start = 1'b1;
                w_div_req.num = {16'd0, w_ay_abs, 8'd0};
                w_div_req.den = {24'd0, w_asp};
            end
            S_STR: begin
                w_div_req.start = 1'b1;
                w_div_req.num = {9'd0, w_minlr, 15'd0};
                w_div_req.den = {24'd0, r_radius};
            end
            S_NX: begin
                w_div_req.start = 1'b1;
                w_div_req.num = {9'd0, r_ax, 15'd0};
                w_div_req.den = {15'd0, r_len};
            end
            S_NY: begin
                w_div_req.start = 1'b1;
                w_div_req.num = {1'b0, r_ay, 15'd0};
                w_div_req.den = {15'd0, r_len};
            end
            default: begin
                w_div_req.start = 1'b0;
            end
        endcase
    end

    assign w_sq_start = (r_state == S_ROOT);

    // Deflections below 0.1 are dropped and full scale is the ceiling.
    function automatic logic [15:0] sat(input logic [16:0] v);
        if (v < {1'b0, THRESH_Q15}) return 16'd0;
        if (v > {1'b0, ONE_Q15}) return ONE_Q15;
        return v[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_x <= '0;
            r_mid_y <= '0;
            r_radius <= '0;
            r_aspect <= 16'd256;
            r_mode <= MODE_AREA;
            r_max_axis <= 1'b0;
            r_enabled <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_AREA_MID_X:    r_mid_x <= i_cfg_data;
                REG_AREA_MID_Y:    r_mid_y <= i_cfg_data;
                REG_STICK_RADIUS:  r_radius <= i_cfg_data;
                REG_ASPECT_RATIO:  r_aspect <= i_cfg_data;
                REG_CENTER_MODE:   r_mode <= i_cfg_data[1:0];
                REG_ONLY_MAX_AXIS: r_max_axis <= i_cfg_data[0];
                REG_ENABLED:       r_enabled <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_cx <= '0;
            r_cy <= '0;
            r_lx <= '0;
            r_ly <= '0;
            r_l <= '0;
            r_r <= '0;
            r_u <= '0;
            r_d <= '0;
            r_act <= 1'b0;
        end else begin
            if (r_valid && !i_stall) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ks <= i_key_state;
                        r_tx <= i_touch_x;
                        r_ty <= i_touch_y;
                        r_ft <= i_frame_time;
                        r_l <= '0;
                        r_r <= '0;
                        r_u <= '0;
                        r_d <= '0;
                        // An inactive frame leaves the stick state untouched.
                        if (!r_enabled || i_key_state == KEY_UP) begin
                            r_act <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_act <= 1'b1;
                            r_state <= (r_mode == MODE_SWIPE) ? S_EASE_X : S_CENTER;
                        end
                    end
                end
                S_EASE_X: begin
                    // Swipe mode pulls the centre toward the previous touch first.
                    r_cx <= w_ease_x;
                    r_state <= S_EASE_Y;
                end
                S_EASE_Y: begin
                    r_cy <= w_ease_y;
                    r_state <= S_CENTER;
                end
                S_CENTER: begin
                    r_lx <= r_tx;
                    r_ly <= r_ty;
                    // On a press the centre jumps; the spare mode code acts as area midpoint.
                    if (r_ks == KEY_PRESSED) begin
                        if (r_mode == MODE_POINT || r_mode == MODE_SWIPE) begin
                            r_cx <= r_tx;
                            r_cy <= r_ty;
                        end else begin
                            r_cx <= r_mid_x;
                            r_cy <= r_mid_y;
                        end
                    end
                    r_state <= S_ASP;
                end
                S_ASP: begin
                    r_xneg <= r_tx < r_cx;
                    r_yneg <= r_ty < r_cy;
                    r_ax <= w_ax_abs;
                    r_state <= S_ASP_W;
                end
                S_ASP_W: begin
                    if (w_div_rsp.done) begin
                        r_ay <= w_div_rsp.quo[23:0];
                        r_state <= S_SQ_X;
                    end
                end
                S_SQ_X: begin
                    r_sq <= {2'd0, w_mp};
                    r_state <= S_SQ_Y;
                end
                S_SQ_Y: begin
                    r_sq <= r_sq + {2'd0, w_mp};
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_state <= S_ROOT_W;
                end
                S_ROOT_W: begin
                    if (w_sq_done) begin
                        r_len <= w_root;
                        // A zero radius or a zero offset gives no deflection at all.
                        if (r_radius == 16'd0 || w_root == '0) r_state <= S_DONE;
                        else r_state <= S_STR;
                    end
                end
                S_STR: begin
                    r_state <= S_STR_W;
                end
                S_STR_W: begin
                    if (w_div_rsp.done) begin
                        r_str <= w_div_rsp.quo[15:0];
                        r_state <= S_NX;
                    end
                end
                S_NX: begin
                    r_state <= S_NX_W;
                end
                S_NX_W: begin
                    if (w_div_rsp.done) begin
                        r_nx <= w_div_rsp.quo[15:0];
                        r_state <= S_NY;
                    end
                end
                S_NY: begin
                    r_state <= S_NY_W;
                end
                S_NY_W: begin
                    if (w_div_rsp.done) begin
                        r_ny <= w_div_rsp.quo[15:0];
                        // A vertical component that rounds to zero counts as downward.
                        if (w_div_rsp.quo[15:0] == 16'd0) r_yneg <= 1'b0;
                        r_state <= S_MUL_X;
                    end
                end
                S_MUL_X: begin
                    r_vx <= w_mp[31:15];
                    r_state <= S_MUL_Y;
                end
                S_MUL_Y: begin
                    r_vy <= w_mp[31:15];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (r_max_axis) begin
                        // Ties between the axes go to the horizontal one.
                        if (r_nx >= r_ny) begin
                            if (!r_xneg || r_nx == 16'd0) r_r <= sat(r_vx);
                            else r_l <= sat(r_vx);
                        end else begin
                            if (!r_yneg) r_d <= sat(r_vy);
                            else r_u <= sat(r_vy);
                        end
                    end else begin
                        if (r_xneg) r_l <= sat(r_vx);
                        else r_r <= sat(r_vx);
                        if (r_yneg) r_u <= sat(r_vy);
                        else r_d <= sat(r_vy);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_left_value = r_l;
    assign o_right_value = r_r;
    assign o_up_value = r_u;
    assign o_down_value = r_d;
    assign o_is_active = r_act;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_left_value))
        else $error("result dropped under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_left_value == 16'd0 || o_right_value == 16'd0)
        else $error("left and right both driven");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_active |-> o_up_value == 16'd0 && o_down_value == 16'd0)
        else $error("inactive result carries deflection");

endmodule

// ----- sim/tta_checker.sv -----
// Checker for the touch-to-thumbstick block: mirrors config, predicts and compares beats.
`timescale 1ns / 100ps
module tta_checker
    import tta_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_in_stall,
    input  logic [1:0]            i_key_state,
    input  logic [15:0]           i_touch_x,
    input  logic [15:0]           i_touch_y,
    input  logic [15:0]           i_frame_time,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [15:0]           i_left_value,
    input  logic [15:0]           i_right_value,
    input  logic [15:0]           i_up_value,
    input  logic [15:0]           i_down_value,
    input  logic                  i_is_active,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic [15:0] up;
        logic [15:0] down;
        logic        active;
    } t_axes;

    t_axes axes_queue[$];

    logic [15:0] mid_x, mid_y, radius, aspect;
    logic [1:0]  mode;
    logic        max_axis, enable;
    logic [15:0] cen_x, cen_y, prev_x, prev_y;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] ease_toward(input logic [15:0] c, input logic [15:0] tgt,
                                                input logic [16:0] frac);
        logic [63:0] p;
        if (tgt >= c) begin
            p = (64'(tgt - c) * frac) >> 16;
            return c + 16'(p);
        end
        p = (64'(c - tgt) * frac) >> 16;
        return c - 16'(p);
    endfunction

    function automatic logic [15:0] gate(input logic [63:0] v);
        if (v < THRESH_Q15) return 16'd0;
        if (v > ONE_Q15) return ONE_Q15;
        return 16'(v);
    endfunction

    // Works out the axes of one frame and advances the stick state.
    task automatic predict_axes(input logic [1:0] ks, input logic [15:0] tx,
                                input logic [15:0] ty, input logic [15:0] ft);
        t_axes       e;
        logic [17:0] t4;
        logic [16:0] frac;
        logic [63:0] ax, ay, len, str, rad, nx, ny, asp, v, l, r, u, d;
        logic        xneg, yneg;
        e = '0;
        l = 0; r = 0; u = 0; d = 0;
        if (enable && ks != KEY_UP) begin
            if (mode == MODE_SWIPE) begin
                t4 = {ft, 2'b00};
                frac = (t4 > 18'h10000) ? 17'h10000 : t4[16:0];
                cen_x = ease_toward(cen_x, prev_x, frac);
                cen_y = ease_toward(cen_y, prev_y, frac);
            end
            prev_x = tx;
            prev_y = ty;
            if (ks == KEY_PRESSED) begin
                if (mode == MODE_POINT || mode == MODE_SWIPE) begin
                    cen_x = tx; cen_y = ty;
                end else begin
                    cen_x = mid_x; cen_y = mid_y;
                end
            end
            xneg = tx < cen_x;
            ax = xneg ? 64'(cen_x - tx) : 64'(tx - cen_x);
            yneg = ty < cen_y;
            ay = yneg ? 64'(cen_y - ty) : 64'(ty - cen_y);
            asp = (aspect != 0) ? 64'(aspect) : 64'd1;
            ay = (ay << 8) / asp;
            len = int_sqrt(ax * ax + ay * ay);
            rad = 64'(radius);
            if (rad != 0 && len != 0) begin
                str = (((len < rad) ? len : rad) << 15) / rad;
                nx = (ax << 15) / len;
                ny = (ay << 15) / len;
                if (ny == 0) yneg = 1'b0;
                if (max_axis) begin
                    if (nx >= ny) begin
                        v = (nx * str) >> 15;
                        if (!xneg || nx == 0) r = v; else l = v;
                    end else begin
                        v = (ny * str) >> 15;
                        if (!yneg) d = v; else u = v;
                    end
                end else begin
                    if (xneg) l = (nx * str) >> 15; else r = (nx * str) >> 15;
                    if (yneg) u = (ny * str) >> 15; else d = (ny * str) >> 15;
                end
            end
            e.left = gate(l);
            e.right = gate(r);
            e.up = gate(u);
            e.down = gate(d);
            e.active = 1'b1;
        end
        axes_queue.push_back(e);
    endtask

    assign o_pending = axes_queue.size();

    always @(posedge i_clk) begin
        t_axes got, want;
        if (!i_rst_n) begin
            mid_x = 0; mid_y = 0; radius = 0; aspect = 16'd256;
            mode = MODE_AREA; max_axis = 0; enable = 1;
            cen_x = 0; cen_y = 0; prev_x = 0; prev_y = 0;
            o_fail_count <= 0;
            axes_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_AREA_MID_X: mid_x = i_cfg_data;
                    REG_AREA_MID_Y: mid_y = i_cfg_data;
                    REG_STICK_RADIUS: radius = i_cfg_data;
                    REG_ASPECT_RATIO: aspect = i_cfg_data;
                    REG_CENTER_MODE: mode = i_cfg_data[1:0];
                    REG_ONLY_MAX_AXIS: max_axis = i_cfg_data[0];
                    REG_ENABLED: enable = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = {i_left_value, i_right_value, i_up_value, i_down_value, i_is_active};
                if (axes_queue.size() == 0) begin
                    $display("%0t: unexpected beat, actual %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = axes_queue.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected l=%0d r=%0d u=%0d d=%0d a=%0d",
                                 $time, want.left, want.right, want.up, want.down,
                                 want.active);
                        $display("%0t:           actual l=%0d r=%0d u=%0d d=%0d a=%0d",
                                 $time, got.left, got.right, got.up, got.down, got.active);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_valid && !i_in_stall)
                predict_axes(i_key_state, i_touch_x, i_touch_y, i_frame_time);
        end
    end

endmodule

// ----- sim/touch_to_thumbstick_axes_test.sv -----
// Testbench top: drives frames and register settings into the stick block, gives the verdict.
`timescale 1ns / 100ps
module touch_to_thumbstick_axes_test;
    import tta_pkg::*;

    // Longest quiet stretch allowed, in clock cycles, before the watchdog stops the run.
    localparam int QUIET_LIMIT = 5000;

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_valid = 0;
    logic                  o_stall;
    logic [1:0]            i_key_state = 0;
    logic [15:0]           i_touch_x = 0, i_touch_y = 0, i_frame_time = 0;
    logic                  o_valid;
    logic                  i_stall = 0;
    logic [15:0]           o_left_value, o_right_value, o_up_value, o_down_value;
    logic                  o_is_active;
    logic                  i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = 0;
    logic [CFG_DATA_W-1:0] i_cfg_data = 0;
    int                    fail_count, pending;
    int                    quiet_cycles = 0;
    bit                    sink_stall_on = 1;

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    touch_to_thumbstick_axes DUT (.*);

    tta_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in_stall(o_stall),
        .i_key_state(i_key_state), .i_touch_x(i_touch_x), .i_touch_y(i_touch_y),
        .i_frame_time(i_frame_time), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_left_value(o_left_value), .i_right_value(o_right_value),
        .i_up_value(o_up_value), .i_down_value(o_down_value), .i_is_active(o_is_active),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // The sink stalls in runs of random length; some stretches it never stalls at all.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) sink_stall_on <= ~sink_stall_on;
        i_stall <= sink_stall_on ? ($urandom_range(0, 3) == 0) : 1'b0;
    end

    // Watchdog: any accepted input or output beat, register write or reset clears the quiet count.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // One beat; valid is held until the block takes it. Each beat starts at the next
    // falling edge, so valid drops between consecutive beats.
    task automatic send_frame(input logic [1:0] ks, input logic [15:0] tx,
                              input logic [15:0] ty, input logic [15:0] ft);
        @(negedge i_clk);
        i_valid <= 1;
        i_key_state <= ks;
        i_touch_x <= tx;
        i_touch_y <= ty;
        i_frame_time <= ft;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        i_valid <= 0;
    endtask

    // Register writes only happen once every expected beat has come back and
    // the block has had time to finish anything in flight.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        while (pending != 0) @(negedge i_clk);
        repeat (250) @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic setup(input logic [15:0] mx, input logic [15:0] my, input logic [15:0] rad,
                         input logic [15:0] asp, input logic [1:0] md, input logic mxa,
                         input logic en);
        write_reg(REG_AREA_MID_X, mx);
        write_reg(REG_AREA_MID_Y, my);
        write_reg(REG_STICK_RADIUS, rad);
        write_reg(REG_ASPECT_RATIO, asp);
        write_reg(REG_CENTER_MODE, {14'd0, md});
        write_reg(REG_ONLY_MAX_AXIS, {15'd0, mxa});
        write_reg(REG_ENABLED, {15'd0, en});
    endtask

    // A gesture: press, a number of held frames drifting around, then release and at times an up frame.
    task automatic gesture(input int holds);
        logic [15:0] x, y;
        x = 16'($urandom);
        y = 16'($urandom);
        send_frame(KEY_PRESSED, x, y, 16'($urandom_range(0, 4000)));
        for (int k = 0; k < holds; k++) begin
            x = x + 16'($urandom_range(0, 8000)) - 16'd4000;
            y = y + 16'($urandom_range(0, 8000)) - 16'd4000;
            if ($urandom_range(0, 7) == 0) begin
                x = 16'($urandom); y = 16'($urandom);
            end
            send_frame(KEY_HELD, x, y, ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                                   : 16'($urandom_range(0, 6000)));
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        send_frame(KEY_RELEASED, x, y, 16'($urandom_range(0, 4000)));
        if ($urandom_range(0, 2) == 0)
            send_frame(KEY_UP, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial begin
        int sent;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed frames at the reset settings: zero radius still updates the state.
        send_frame(KEY_PRESSED, 16'hFFFF, 16'h0000, 16'h0000);
        send_frame(KEY_HELD, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_frame(KEY_UP, 16'h1234, 16'h5678, 16'h0001);

        // Area centre, generous radius, zero aspect treated as its smallest value.
        setup(16'h8000, 16'h8000, 16'h2000, 16'h0000, MODE_AREA, 1'b0, 1'b1);
        send_frame(KEY_PRESSED, 16'h8000, 16'h8000, 16'h0100);
        send_frame(KEY_HELD, 16'h8000, 16'h8001, 16'h0100);
        send_frame(KEY_HELD, 16'h9000, 16'h7000, 16'h0100);
        send_frame(KEY_HELD, 16'h0000, 16'hFFFF, 16'h0100);
        send_frame(KEY_RELEASED, 16'h8100, 16'h8000, 16'h0100);

        // Max-axis ties and both signs, square aspect.
        setup(16'h8000, 16'h8000, 16'h1000, 16'h0100, MODE_AREA, 1'b1, 1'b1);
        send_frame(KEY_PRESSED, 16'h8400, 16'h8400, 16'h0000);
        send_frame(KEY_HELD, 16'h7C00, 16'h7C00, 16'h0000);
        send_frame(KEY_HELD, 16'h8000, 16'h7000, 16'h0000);
        send_frame(KEY_HELD, 16'h8000, 16'h9000, 16'h0000);
        send_frame(KEY_HELD, 16'h8000, 16'h8000, 16'h0000);

        // Swipe with the easing fraction saturated, then the unused mode, then disabled.
        setup(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, MODE_SWIPE, 1'b0, 1'b1);
        send_frame(KEY_PRESSED, 16'h4000, 16'h4000, 16'hFFFF);
        send_frame(KEY_HELD, 16'hC000, 16'h2000, 16'h4000);
        send_frame(KEY_HELD, 16'h0000, 16'hFFFF, 16'h2000);
        write_reg(REG_CENTER_MODE, {14'd0, MODE_SPARE});
        send_frame(KEY_PRESSED, 16'hFFFF, 16'h0000, 16'h8000);
        write_reg(REG_ENABLED, 16'd0);
        send_frame(KEY_PRESSED, 16'h1111, 16'h2222, 16'h3333);
        send_frame(KEY_HELD, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Random part: mostly well-formed gestures, in phases with random settings.
        sent = 0;
        while (sent < 1100) begin
            setup(16'($urandom), 16'($urandom),
                  ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)),
                  ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(64, 1024)),
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 9) != 0);
            for (int g = 0; g < 8; g++) begin
                if ($urandom_range(0, 4) == 0) begin
                    for (int n = 0; n < 6; n++)
                        send_frame(2'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom));
                    sent += 6;
                end else begin
                    int holds;
                    holds = $urandom_range(0, 14);
                    gesture(holds);
                    sent += holds + 2;
                end
                repeat ($urandom_range(0, 40)) @(negedge i_clk);
            end
        end

        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
